// ===== hdl/durs_pkg.sv =====
// Shared types and constants for the dual ultrasonic ranging sequencer.
// No dependencies; every module in hdl/ imports this package.
package durs_pkg;

    // Sequencer phases: A low, A high, A listen, A gap, then the same for B
    typedef enum logic [2:0] {
        PH_A_LOW    = 3'd0,
        PH_A_HIGH   = 3'd1,
        PH_A_LISTEN = 3'd2,
        PH_A_GAP    = 3'd3,
        PH_B_LOW    = 3'd4,
        PH_B_HIGH   = 3'd5,
        PH_B_LISTEN = 3'd6,
        PH_B_GAP    = 3'd7
    } phase_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRIGGER_WIDTH = 3'd0,
        CFG_LISTEN_A      = 3'd1,
        CFG_LISTEN_B      = 3'd2,
        CFG_GAP_AFTER_A   = 3'd3,
        CFG_GAP_AFTER_B   = 3'd4,
        CFG_MAX_PULSE_A   = 3'd5,
        CFG_MAX_PULSE_B   = 3'd6,
        CFG_UNUSED        = 3'd7
    } cfg_index_t;

    // Refresh codes on the updated field
    localparam logic [1:0] UPD_NONE = 2'd0;
    localparam logic [1:0] UPD_A    = 2'd1;
    localparam logic [1:0] UPD_B    = 2'd2;

    localparam int unsigned TICK_W  = 17;
    localparam int unsigned DIST_W  = 20;
    localparam int unsigned CFG_W   = 17;

    localparam logic [TICK_W-1:0] PRE_LOW_TICKS = 17'd2;
    localparam logic [TICK_W-1:0] COUNT_MAX     = 17'h1FFFF;

    // Distance in Q8 cm: pulse * 281 >> 6
    localparam logic [8:0]  Q8_MUL   = 9'd281;
    localparam int unsigned Q8_SHIFT = 6;
    localparam int unsigned PROD_W   = TICK_W + 9;

    typedef struct packed {
        logic [7:0]        trigger_width;
        logic [TICK_W-1:0] listen_a;
        logic [TICK_W-1:0] listen_b;
        logic [TICK_W-1:0] gap_after_a;
        logic [TICK_W-1:0] gap_after_b;
        logic [TICK_W-1:0] max_pulse_a;
        logic [TICK_W-1:0] max_pulse_b;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        trigger_width: 8'd10,
        listen_a:      17'd40000,
        listen_b:      17'd75000,
        gap_after_a:   17'd10000,
        gap_after_b:   17'd20000,
        max_pulse_a:   17'd38000,
        max_pulse_b:   17'd60000
    };

    // Phase status passed from the sequencer to the echo timer
    typedef struct packed {
        phase_t phase;
        logic   on_b;
        logic   listening;
        logic   phase_end;
        logic   enter_low;
    } phase_info_t;

    typedef struct packed {
        logic echo_a;
        logic echo_b;
    } durs_in_t;

    typedef struct packed {
        logic              trig_a;
        logic              trig_b;
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
        logic [1:0]        updated;
    } durs_out_t;

endpackage

// ===== hdl/dual_ultrasonic_ranging_sequencer_unit.sv =====
// Dual ultrasonic ranging sequencer, top level.
// Pipeline: a tick transferred in passes the input register, then the result
// register; one tick per cycle is taken sustained while the receiver accepts
// results, limited only by the single-stage step logic and one 17x9 multiplier.
// Reset: sequencer at sensor A pre-trigger low, distances zero, registers
// at their documented defaults. Depends on durs_pkg and the two submodules.
module dual_ultrasonic_ranging_sequencer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  durs_pkg::durs_in_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output durs_pkg::durs_out_t        out_data,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [durs_pkg::CFG_W-1:0] cfg_wdata
);
    import durs_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    durs_in_t    in_data_reg;
    logic        out_valid_reg;
    logic        trig_a_reg, trig_b_reg;
    logic [1:0]  updated_reg;
    logic        advance;
    phase_info_t info;
    logic [1:0]  updated;
    logic [DIST_W-1:0] dist_a, dist_b;

    // Step the sequencer when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TRIGGER_WIDTH: cfg_reg.trigger_width <= cfg_wdata[7:0];
                CFG_LISTEN_A:      cfg_reg.listen_a      <= cfg_wdata;
                CFG_LISTEN_B:      cfg_reg.listen_b      <= cfg_wdata;
                CFG_GAP_AFTER_A:   cfg_reg.gap_after_a   <= cfg_wdata;
                CFG_GAP_AFTER_B:   cfg_reg.gap_after_b   <= cfg_wdata;
                CFG_MAX_PULSE_A:   cfg_reg.max_pulse_a   <= cfg_wdata;
                CFG_MAX_PULSE_B:   cfg_reg.max_pulse_b   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Capture the incoming tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    durs_phase_ctrl u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cfg   (cfg_reg),
        .info  (info)
    );

    durs_echo_meas u_echo (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .info        (info),
        .echo_a      (in_data_reg.echo_a),
        .echo_b      (in_data_reg.echo_b),
        .max_pulse_a (cfg_reg.max_pulse_a),
        .max_pulse_b (cfg_reg.max_pulse_b),
        .dist_a      (dist_a),
        .dist_b      (dist_b),
        .updated     (updated)
    );

    // Load the result register; distances live in the hold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            trig_a_reg  <= (info.phase == PH_A_HIGH);
            trig_b_reg  <= (info.phase == PH_B_HIGH);
            updated_reg <= updated;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data.trig_a  = trig_a_reg;
    assign out_data.trig_b  = trig_b_reg;
    assign out_data.dist_a  = dist_a;
    assign out_data.dist_b  = dist_b;
    assign out_data.updated = updated_reg;

    // Both triggers are never driven in the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.trig_a && out_data.trig_b))
        else $error("both trigger lines high");

    // A distance refresh only happens as the phase moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && updated != UPD_NONE) |=> (info.phase != $past(info.phase)))
        else $error("distance refreshed without phase change");

    // A refresh of either distance never happens while a trigger is being driven
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.updated != UPD_NONE) |->
        (!out_data.trig_a && !out_data.trig_b))
        else $error("refresh during trigger phase");

    // A buffered tick with a free result register moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("tick stalled with free result register");

endmodule

// ===== hdl/durs_phase_ctrl.sv =====
// Phase sequencer: phase register and tick timer for both sensors.
// Depends on durs_pkg.
module durs_phase_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  durs_pkg::cfg_t       cfg,
    output durs_pkg::phase_info_t info
);
    import durs_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] timer_reg, timer_next;
    logic [TICK_W-1:0] len;
    logic [TICK_W:0]   timer_inc;
    phase_t            succ;

    // Select the length of the current phase, zero taken as one tick
    always_comb
    begin
        case (phase_reg)
            PH_A_LOW, PH_B_LOW:   len = PRE_LOW_TICKS;
            PH_A_HIGH, PH_B_HIGH: len = {{(TICK_W-8){1'b0}}, cfg.trigger_width};
            PH_A_LISTEN:          len = cfg.listen_a;
            PH_A_GAP:             len = cfg.gap_after_a;
            PH_B_LISTEN:          len = cfg.listen_b;
            default:              len = cfg.gap_after_b;
        endcase
        if (len == '0)
        begin
            len = {{(TICK_W-1){1'b0}}, 1'b1};
        end
    end

    // Pick the following phase, skip a gap of zero
    always_comb
    begin
        case (phase_reg)
            PH_A_LISTEN: succ = (cfg.gap_after_a == '0) ? PH_B_LOW : PH_A_GAP;
            PH_B_LISTEN: succ = (cfg.gap_after_b == '0) ? PH_A_LOW : PH_B_GAP;
            default:     succ = phase_t'(phase_reg + 3'd1);
        endcase
    end

    assign timer_inc = {1'b0, timer_reg} + {{TICK_W{1'b0}}, 1'b1};

    always_comb
    begin
        info.phase     = phase_reg;
        info.on_b      = (phase_reg == PH_A_GAP) || (phase_reg == PH_B_LOW) ||
                         (phase_reg == PH_B_HIGH) || (phase_reg == PH_B_LISTEN);
        info.listening = (phase_reg == PH_A_LISTEN) || (phase_reg == PH_B_LISTEN);
        info.phase_end = (timer_inc >= {1'b0, len});
        info.enter_low = info.phase_end && ((succ == PH_A_LOW) || (succ == PH_B_LOW));

        phase_next = phase_reg;
        timer_next = timer_reg;
        if (step)
        begin
            if (info.phase_end)
            begin
                phase_next = succ;
                timer_next = '0;
            end
            else
            begin
                timer_next = timer_inc[TICK_W-1:0];
            end
        end
    end

    // Hold phase and timer between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_A_LOW;
            timer_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// ===== hdl/durs_echo_meas.sv =====
// Echo pulse timer and distance conversion for the active sensor.
// Depends on durs_pkg; phase status comes from durs_phase_ctrl.
module durs_echo_meas (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  durs_pkg::phase_info_t       info,
    input  logic                        echo_a,
    input  logic                        echo_b,
    input  logic [durs_pkg::TICK_W-1:0] max_pulse_a,
    input  logic [durs_pkg::TICK_W-1:0] max_pulse_b,
    output logic [durs_pkg::DIST_W-1:0] dist_a,
    output logic [durs_pkg::DIST_W-1:0] dist_b,
    output logic [1:0]                  updated
);
    import durs_pkg::*;

    logic              prev_reg, prev_next;
    logic              seen_reg, seen_next;
    logic              ready_reg, ready_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0] latch_reg, latch_next;
    logic [DIST_W-1:0] dist_a_reg, dist_a_next;
    logic [DIST_W-1:0] dist_b_reg, dist_b_next;
    logic              lvl;
    logic [TICK_W-1:0] limit;
    logic [PROD_W-1:0] prod;

    assign lvl   = info.on_b ? echo_b : echo_a;
    assign limit = info.on_b ? max_pulse_b : max_pulse_a;
    assign prod  = PROD_W'(latch_next) * PROD_W'(Q8_MUL);

    always_comb
    begin
        prev_next   = prev_reg;
        seen_next   = seen_reg;
        ready_next  = ready_reg;
        count_next  = count_reg;
        latch_next  = latch_reg;
        dist_a_next = dist_a_reg;
        dist_b_next = dist_b_reg;
        updated     = UPD_NONE;

        // Time the echo pulse inside the listen window
        if (info.listening)
        begin
            if (lvl && !prev_reg)
            begin
                seen_next  = 1'b1;
                count_next = {{(TICK_W-1){1'b0}}, 1'b1};
            end
            else if (lvl && seen_reg)
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + {{(TICK_W-1){1'b0}}, 1'b1};
                end
            end
            else if (!lvl && prev_reg && seen_reg)
            begin
                latch_next = (count_reg > limit) ? '0 : count_reg;
                ready_next = 1'b1;
                seen_next  = 1'b0;
            end
        end
        prev_next = lvl;

        // Convert a measured pulse when the window closes
        if (info.phase_end && info.listening && ready_next)
        begin
            if (info.on_b)
            begin
                dist_b_next = prod[Q8_SHIFT +: DIST_W];
                updated     = UPD_B;
            end
            else
            begin
                dist_a_next = prod[Q8_SHIFT +: DIST_W];
                updated     = UPD_A;
            end
        end

        // Drop any pending pulse when a new trigger cycle starts
        if (info.enter_low)
        begin
            ready_next = 1'b0;
            seen_next  = 1'b0;
        end

        if (!step)
        begin
            updated = UPD_NONE;
        end
    end

    // Advance measurement state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            seen_reg   <= 1'b0;
            ready_reg  <= 1'b0;
            count_reg  <= '0;
            latch_reg  <= '0;
            dist_a_reg <= '0;
            dist_b_reg <= '0;
        end
        else if (step)
        begin
            prev_reg   <= prev_next;
            seen_reg   <= seen_next;
            ready_reg  <= ready_next;
            count_reg  <= count_next;
            latch_reg  <= latch_next;
            dist_a_reg <= dist_a_next;
            dist_b_reg <= dist_b_next;
        end
    end

    assign dist_a = dist_a_reg;
    assign dist_b = dist_b_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the dual ultrasonic ranging sequencer: drives
// echo ticks, predicts every trigger, distance and refresh, and compares each
// result transfer. Depends on durs_pkg and dual_ultrasonic_ranging_sequencer_unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import durs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    durs_in_t         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    durs_out_t        out_data;
    logic             cfg_we    = 1'b0;
    cfg_index_t       cfg_index = CFG_TRIGGER_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Sequencer mirror: settings and state as they stand after the last tick
    cfg_t              seq_cfg    = CFG_RESET;
    phase_t            seq_phase  = PH_A_LOW;
    logic [TICK_W-1:0] seq_timer  = '0;
    logic [TICK_W-1:0] seq_count  = '0;
    logic [TICK_W-1:0] seq_latch  = '0;
    logic              seq_rise   = 1'b0;
    logic              seq_ready  = 1'b0;
    logic              seq_prev   = 1'b0;
    logic [DIST_W-1:0] seq_dist_a = '0;
    logic [DIST_W-1:0] seq_dist_b = '0;

    durs_out_t expected_ticks[$];
    int        error_count   = 0;
    int        ticks_sent    = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        hold_serial   = 0;
    int        hold_taken    = 0;
    int        hold_left     = 0;
    int        quiet_cycles  = 0;

    dual_ultrasonic_ranging_sequencer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Length of a phase in ticks; zero-length settings count as one tick
    function automatic logic [TICK_W-1:0] phase_span(input phase_t ph);
        logic [TICK_W-1:0] n;
        case (ph)
            PH_A_LOW, PH_B_LOW:   n = PRE_LOW_TICKS;
            PH_A_HIGH, PH_B_HIGH: n = {9'd0, seq_cfg.trigger_width};
            PH_A_LISTEN:          n = seq_cfg.listen_a;
            PH_A_GAP:             n = seq_cfg.gap_after_a;
            PH_B_LISTEN:          n = seq_cfg.listen_b;
            default:              n = seq_cfg.gap_after_b;
        endcase
        return (n == '0) ? 17'd1 : n;
    endfunction

    // Advance the mirror by one tick and return the result it must produce
    function automatic durs_out_t advance_sequencer(input durs_in_t t);
        durs_out_t         r;
        phase_t            cur;
        logic              lvl;
        logic              on_b;
        logic              listening;
        logic [TICK_W-1:0] limit;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] shifted;
        logic [2:0]        nxt;
        cur       = seq_phase;
        on_b      = (cur == PH_A_GAP) || (cur == PH_B_LOW) || (cur == PH_B_HIGH)
                    || (cur == PH_B_LISTEN);
        listening = (cur == PH_A_LISTEN) || (cur == PH_B_LISTEN);
        lvl       = on_b ? t.echo_b : t.echo_a;
        r         = '0;
        r.trig_a  = (cur == PH_A_HIGH);
        r.trig_b  = (cur == PH_B_HIGH);
        r.updated = UPD_NONE;

        // Time the echo pulse; a fall counts only after a rise in this window
        if (listening)
        begin
            if (lvl && !seq_prev)
            begin
                seq_rise  = 1'b1;
                seq_count = 17'd1;
            end
            else if (lvl && seq_rise)
            begin
                if (seq_count != COUNT_MAX)
                    seq_count = seq_count + 17'd1;
            end
            else if (!lvl && seq_prev && seq_rise)
            begin
                limit     = on_b ? seq_cfg.max_pulse_b : seq_cfg.max_pulse_a;
                seq_latch = (seq_count > limit) ? '0 : seq_count;
                seq_ready = 1'b1;
                seq_rise  = 1'b0;
            end
        end
        seq_prev = lvl;

        // Close the phase; a listen window with a measured pulse refreshes a distance
        if ({1'b0, seq_timer} + 18'd1 >= {1'b0, phase_span(cur)})
        begin
            seq_timer = '0;
            if (listening && seq_ready)
            begin
                prod    = PROD_W'(seq_latch) * PROD_W'(Q8_MUL);
                shifted = prod >> Q8_SHIFT;
                if (on_b)
                begin
                    seq_dist_b = shifted[DIST_W-1:0];
                    r.updated  = UPD_B;
                end
                else
                begin
                    seq_dist_a = shifted[DIST_W-1:0];
                    r.updated  = UPD_A;
                end
            end
            if (cur == PH_A_LISTEN)
                seq_phase = (seq_cfg.gap_after_a == '0) ? PH_B_LOW : PH_A_GAP;
            else if (cur == PH_B_LISTEN)
                seq_phase = (seq_cfg.gap_after_b == '0) ? PH_A_LOW : PH_B_GAP;
            else
            begin
                nxt       = cur + 3'd1;
                seq_phase = phase_t'(nxt);
            end
            if (seq_phase == PH_A_LOW || seq_phase == PH_B_LOW)
            begin
                seq_ready = 1'b0;
                seq_rise  = 1'b0;
            end
        end
        else
            seq_timer = seq_timer + 17'd1;

        r.dist_a = seq_dist_a;
        r.dist_b = seq_dist_b;
        return r;
    endfunction

    // Offer one tick, idling first at random, and hold it until the transfer
    task automatic send_tick(input durs_in_t t);
        int idle;
        idle = 0;
        while (idle < 40 && $urandom_range(99) < send_idle_pct)
            idle++;
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_ticks.push_back(advance_sequencer(t));
        ticks_sent++;
    endtask

    // Drive the chosen sensor's echo level; the other line carries noise
    task automatic send_echo(input bit on_b, input bit lvl);
        durs_in_t t;
        t.echo_a = on_b ? 1'($urandom_range(1)) : lvl;
        t.echo_b = on_b ? lvl : 1'($urandom_range(1));
        send_tick(t);
    endtask

    task automatic send_noise(input int count);
        durs_in_t t;
        repeat (count)
        begin
            t = 2'($urandom_range(3));
            send_tick(t);
        end
    endtask

    // Advance to the first tick of a listen window, holding the echo at pre_lvl
    task automatic run_to_listen(input bit on_b, input bit pre_lvl);
        phase_t target;
        target = on_b ? PH_B_LISTEN : PH_A_LISTEN;
        while (!(seq_phase == target && seq_timer == '0))
            send_echo(on_b, pre_lvl);
    endtask

    // Play an 8-tick echo pattern, first tick in the top bit
    task automatic play_pattern(input bit on_b, input bit pre_lvl, input logic [7:0] pat);
        int i;
        run_to_listen(on_b, pre_lvl);
        for (i = 7; i >= 0; i--)
            send_echo(on_b, pat[i]);
    endtask

    // One full window of random high and low runs
    task automatic play_random_window(input bit on_b);
        int wlen;
        int i;
        int run;
        bit lvl;
        run_to_listen(on_b, $urandom_range(9) == 0);
        wlen = int'(phase_span(on_b ? PH_B_LISTEN : PH_A_LISTEN));
        lvl  = ($urandom_range(4) == 0);
        i    = 0;
        while (i < wlen)
        begin
            run = $urandom_range(1, (wlen > 3) ? wlen / 2 : 1);
            while (run > 0 && i < wlen)
            begin
                send_echo(on_b, lvl);
                run--;
                i++;
            end
            lvl = !lvl;
        end
    endtask

    // Drop valid and wait for every outstanding result, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_TRIGGER_WIDTH: seq_cfg.trigger_width = value[7:0];
            CFG_LISTEN_A:      seq_cfg.listen_a      = value;
            CFG_LISTEN_B:      seq_cfg.listen_b      = value;
            CFG_GAP_AFTER_A:   seq_cfg.gap_after_a   = value;
            CFG_GAP_AFTER_B:   seq_cfg.gap_after_b   = value;
            CFG_MAX_PULSE_A:   seq_cfg.max_pulse_a   = value;
            CFG_MAX_PULSE_B:   seq_cfg.max_pulse_b   = value;
            default:           ;
        endcase
    endtask

    // Rewrite every register while idle; junk in the upper trigger bits is dropped
    task automatic load_settings(input cfg_t c);
        drain();
        write_reg(CFG_TRIGGER_WIDTH, {9'($urandom_range(511)), c.trigger_width});
        write_reg(CFG_LISTEN_A, c.listen_a);
        write_reg(CFG_LISTEN_B, c.listen_b);
        write_reg(CFG_GAP_AFTER_A, c.gap_after_a);
        write_reg(CFG_GAP_AFTER_B, c.gap_after_b);
        write_reg(CFG_MAX_PULSE_A, c.max_pulse_a);
        write_reg(CFG_MAX_PULSE_B, c.max_pulse_b);
        write_reg(CFG_UNUSED, 17'($urandom_range(131071)));
        cfg_we <= 1'b0;
    endtask

    // Short phases so that windows close often
    function automatic cfg_t make_small_settings();
        cfg_t c;
        c.trigger_width = 8'($urandom_range(1, 4));
        c.listen_a      = 17'($urandom_range(4, 20));
        c.listen_b      = 17'($urandom_range(4, 20));
        c.gap_after_a   = 17'($urandom_range(0, 4));
        c.gap_after_b   = 17'($urandom_range(0, 4));
        c.max_pulse_a   = 17'($urandom_range(1, 20));
        c.max_pulse_b   = 17'($urandom_range(1, 20));
        return c;
    endfunction

    task automatic test_reset_defaults();
        send_noise(20);
    endtask

    task automatic test_window_cases();
        load_settings('{trigger_width: 8'd1, listen_a: 17'd8, listen_b: 17'd8,
                        gap_after_a: 17'd0, gap_after_b: 17'd0,
                        max_pulse_a: 17'd4, max_pulse_b: 17'd131071});
        // echo already high at window start, then a fall with no rise
        play_pattern(1'b0, 1'b1, 8'b1100_0000);
        // two pulses, the later one wins
        play_pattern(1'b1, 1'b0, 8'b0110_1110);
        // pulse longer than the A limit reads as zero
        play_pattern(1'b0, 1'b0, 8'b0111_1100);
        // a rise left open keeps the earlier completed pulse
        play_pattern(1'b1, 1'b0, 8'b1001_1111);
        // pulse within the A limit
        play_pattern(1'b0, 1'b0, 8'b0011_1000);
        // pulse still high at window end is not measured
        play_pattern(1'b0, 1'b0, 8'b0001_1111);
    endtask

    task automatic test_extreme_settings();
        // zero trigger width and windows act as one tick, zero gaps are skipped
        load_settings('{trigger_width: 8'd0, listen_a: 17'd0, listen_b: 17'd0,
                        gap_after_a: 17'd0, gap_after_b: 17'd0,
                        max_pulse_a: 17'd1, max_pulse_b: 17'd1});
        send_noise(24);
        load_settings('{trigger_width: 8'd24, listen_a: 17'd131071, listen_b: 17'd131071,
                        gap_after_a: 17'd131071, gap_after_b: 17'd131071,
                        max_pulse_a: 17'd131071, max_pulse_b: 17'd131071});
        send_noise(40);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        load_settings(make_small_settings());
        // long receiver hold while ticks keep coming, so the input backs up
        hold_serial++;
        send_noise(40);
        // sender pauses until every result is back
        drain();
        play_random_window(1'b0);
        play_random_window(1'b1);
    endtask

    task automatic test_random_ranging();
        int mode;
        int goal;
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 55; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            load_settings(make_small_settings());
            goal = ticks_sent + 30;
            while (ticks_sent < goal)
            begin
                if ($urandom_range(99) < 80)
                    play_random_window(1'($urandom_range(1)));
                else
                    send_noise($urandom_range(1, 10));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_window_cases();
        test_extreme_settings();
        test_backpressure();
        test_random_ranging();
        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: honor a requested hold, otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_serial != hold_taken)
        begin
            hold_taken = hold_serial;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic note_field(input string name, input logic [DIST_W-1:0] want,
                              input logic [DIST_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        durs_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_ticks.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("result transfer with nothing expected");
            end
            else
            begin
                want = expected_ticks.pop_front();
                note_field("trig_a", DIST_W'(want.trig_a), DIST_W'(out_data.trig_a));
                note_field("trig_b", DIST_W'(want.trig_b), DIST_W'(out_data.trig_b));
                note_field("dist_a", want.dist_a, out_data.dist_a);
                note_field("dist_b", want.dist_b, out_data.dist_b);
                note_field("updated", DIST_W'(want.updated), DIST_W'(out_data.updated));
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
hdl/durs_pkg.sv
hdl/durs_phase_ctrl.sv
hdl/durs_echo_meas.sv
hdl/dual_ultrasonic_ranging_sequencer_unit.sv
verif/testbench.sv
